/* sv/blflg_pkg.sv */
package blflg_pkg;

    // Field widths of the stream words
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 4;
    localparam int PCT_W    = 7;
    localparam int CFG_W    = 24;

    // Input word layout, lowest bit up
    localparam int IN_BUSY_LSB  = 0;
    localparam int IN_TOTAL_LSB = IN_BUSY_LSB + SAMPLE_W;
    localparam int IN_LEVEL_LSB = IN_TOTAL_LSB + SAMPLE_W;
    localparam int IN_TDATA_W   = ((IN_LEVEL_LSB + LEVEL_W + 7) / 8) * 8;

    // Input side-band: level-known flag
    localparam int IN_KNOWN_BIT = 0;
    localparam int IN_TUSER_W   = 1;

    // Output word layout: chosen level
    localparam int OUT_LEVEL_LSB = 0;
    localparam int OUT_TDATA_W   = ((OUT_LEVEL_LSB + LEVEL_W + 7) / 8) * 8;

    // Output side-band, lowest bit up
    localparam int OUT_DECIDED_BIT = 0;
    localparam int OUT_GOMAX_BIT   = 1;
    localparam int OUT_TUSER_W     = 2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_UP_THR   = 3'd0,
        CFG_DOWN_THR = 3'd1,
        CFG_CONS     = 3'd2,
        CFG_SLOWEST  = 3'd3,
        CFG_FLOOR    = 3'd4,
        CFG_CEILING  = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic [PCT_W-1:0]   RST_UP_THR   = 7'd50;
    localparam logic [PCT_W-1:0]   RST_DOWN_THR = 7'd20;
    localparam logic [PCT_W-1:0]   RST_CONS     = 7'd0;
    localparam logic [LEVEL_W-1:0] RST_SLOWEST  = 4'd15;
    localparam logic [CFG_W-1:0]   RST_FLOOR    = 24'd5000;
    localparam logic [CFG_W-1:0]   RST_CEILING  = 24'd50000;

    // Percent base
    localparam int PCT = 100;

endpackage

/* sv/busy_load_frequency_level_governor.sv */
// Load-threshold frequency level governor. Each input word is one poll sample
// (busy time, total time, current level, level-known flag); both times add into
// saturating TIME_WIDTH-bit accumulators, and each sample yields exactly one
// output word: no decision, go to maximum frequency, or a level one step faster,
// one step slower (capped at the slowest level) or unchanged, based on load =
// 100*busy/total against thresholds scaled by (100+conservativeness)/100.
// Accumulators clear after any decision. The block takes one sample at a time:
// a sample with no decision or a forced maximum passes S_ACC, S_CHK and S_DEC; a
// sample that needs the load also waits in S_DIV for the bit-serial divider that
// forms one quotient bit per cycle. S_DEC holds until the output register is free;
// a finished word may wait in that register while the next sample is accepted.
module busy_load_frequency_level_governor
    import blflg_pkg::*;
#(
    parameter int LEVEL_COUNT = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // busy_sample[23:0], total_sample[47:24], current_level[51:48]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // level_known[0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // decision stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_level[3:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // decided[0], go_max[1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int TW      = TIME_WIDTH;
    localparam int DVD_W   = TW + 7;
    localparam int LVL_MAX = LEVEL_COUNT - 1;
    localparam int LOAD_W  = 10;
    localparam int THR_W   = 15;
    localparam int CMP_W   = 17;

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_CHK, S_DIV, S_DEC} t_state;
    typedef enum logic [1:0] {K_NONE, K_MAX, K_LEVEL} t_kind;

    // config registers
    logic [PCT_W-1:0]   r_up_thr;
    logic [PCT_W-1:0]   r_down_thr;
    logic [PCT_W-1:0]   r_cons;
    logic [LEVEL_W-1:0] r_slowest;
    logic [CFG_W-1:0]   r_floor;
    logic [CFG_W-1:0]   r_ceiling;

    // sequencer and datapath registers
    t_state              r_state;
    t_kind               r_kind;
    logic [TW-1:0]       r_bacc;
    logic [TW-1:0]       r_tacc;
    logic [SAMPLE_W-1:0] r_busy_s;
    logic [SAMPLE_W-1:0] r_total_s;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_known;
    logic [THR_W-1:0]    r_p;
    logic [THR_W-1:0]    r_q_thr;
    logic [LOAD_W-1:0]   r_load;
    logic                r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic [OUT_TUSER_W-1:0] r_ouser;

    logic [TW:0]         w_bsum;
    logic [TW:0]         w_tsum;
    logic [7:0]          w_scale;
    logic [DVD_W-1:0]    w_dividend;
    logic                w_no_dec;
    logic                w_force_max;
    logic                w_div_start;
    logic                w_div_done;
    logic [DVD_W-1:0]    w_quot;
    logic [CMP_W-1:0]    w_l100;
    logic [CMP_W-1:0]    w_l1_100;
    logic                w_faster;
    logic                w_slower;
    logic [6:0]          w_top;
    logic [6:0]          w_inc;
    logic [LEVEL_W-1:0]  w_new_level;
    logic                w_out_free;
    logic [OUT_TDATA_W-1:0] w_odata;
    logic [OUT_TUSER_W-1:0] w_ouser;

    // saturating sums, threshold scale, dividend 100*busy
    always_comb begin
        w_bsum     = {1'b0, r_bacc} + (TW+1)'(r_busy_s);
        w_tsum     = {1'b0, r_tacc} + (TW+1)'(r_total_s);
        w_scale    = 8'(PCT) + {1'b0, r_cons};
        w_dividend = (DVD_W'(r_bacc) << 6) + (DVD_W'(r_bacc) << 5) + (DVD_W'(r_bacc) << 2);
    end

    // decision gating
    always_comb begin
        w_no_dec    = (r_total_s == '0) || (r_tacc < TW'(r_floor));
        w_force_max = !r_known || (32'(r_level) >= 32'(LEVEL_COUNT))
                      || (r_bacc > TW'(r_ceiling));
        w_div_start = (r_state == S_CHK) && !w_no_dec && !w_force_max;
    end

    // load against thresholds: load > P/100 iff 100*load > P,
    // load+1 <= Q/100 iff 100*(load+1) <= Q
    always_comb begin
        w_l100   = CMP_W'(r_load) * CMP_W'(PCT);
        w_l1_100 = (CMP_W'(r_load) + CMP_W'(1)) * CMP_W'(PCT);
        w_faster = (CMP_W'(r_p) < w_l100);
        w_slower = (w_l1_100 <= CMP_W'(r_q_thr));
        w_top    = (7'(r_slowest) > 7'(LVL_MAX)) ? 7'(LVL_MAX) : 7'(r_slowest);
        w_inc    = 7'(r_level) + 7'd1;
        if (w_faster) begin
            w_new_level = (r_level != '0) ? r_level - LEVEL_W'(1) : r_level;
        end else if (w_slower) begin
            w_new_level = (w_inc > w_top) ? LEVEL_W'(w_top) : LEVEL_W'(w_inc);
        end else begin
            w_new_level = r_level;
        end
    end

    // output word assembly
    always_comb begin
        w_odata = '0;
        w_ouser = '0;
        case (r_kind)
            K_MAX: begin
                w_ouser[OUT_DECIDED_BIT] = 1'b1;
                w_ouser[OUT_GOMAX_BIT]   = 1'b1;
            end
            K_LEVEL: begin
                w_ouser[OUT_DECIDED_BIT] = 1'b1;
                w_odata[OUT_LEVEL_LSB +: LEVEL_W] = w_new_level;
            end
            default: begin
                w_odata = '0;
                w_ouser = '0;
            end
        endcase
        w_out_free = !r_ovalid || m_axis_tready;
    end

    blflg_div #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_tacc),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr   <= RST_UP_THR;
            r_down_thr <= RST_DOWN_THR;
            r_cons     <= RST_CONS;
            r_slowest  <= RST_SLOWEST;
            r_floor    <= RST_FLOOR;
            r_ceiling  <= RST_CEILING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UP_THR:   r_up_thr   <= i_cfg_data[PCT_W-1:0];
                CFG_DOWN_THR: r_down_thr <= i_cfg_data[PCT_W-1:0];
                CFG_CONS:     r_cons     <= i_cfg_data[PCT_W-1:0];
                CFG_SLOWEST:  r_slowest  <= i_cfg_data[LEVEL_W-1:0];
                CFG_FLOOR:    r_floor    <= i_cfg_data;
                CFG_CEILING:  r_ceiling  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_NONE;
            r_bacc   <= '0;
            r_tacc   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_DEC reloads the output register itself
            if (r_ovalid && m_axis_tready && (r_state != S_DEC)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_busy_s  <= s_axis_tdata[IN_BUSY_LSB +: SAMPLE_W];
                        r_total_s <= s_axis_tdata[IN_TOTAL_LSB +: SAMPLE_W];
                        r_level   <= s_axis_tdata[IN_LEVEL_LSB +: LEVEL_W];
                        r_known   <= s_axis_tuser[IN_KNOWN_BIT];
                        r_state   <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_bacc  <= w_bsum[TW] ? '1 : w_bsum[TW-1:0];
                    r_tacc  <= w_tsum[TW] ? '1 : w_tsum[TW-1:0];
                    r_p     <= THR_W'(r_up_thr) * THR_W'(w_scale);
                    r_q_thr <= THR_W'(r_down_thr) * THR_W'(w_scale);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_no_dec) begin
                        r_kind  <= K_NONE;
                        r_state <= S_DEC;
                    end else if (w_force_max) begin
                        r_kind  <= K_MAX;
                        r_state <= S_DEC;
                    end else begin
                        r_kind  <= K_LEVEL;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        // clamp: any load of 512 or more beats every threshold
                        r_load  <= (|w_quot[DVD_W-1:LOAD_W-1]) ? LOAD_W'(512)
                                   : {1'b0, w_quot[LOAD_W-2:0]};
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_out_free) begin
                        r_odata  <= w_odata;
                        r_ouser  <= w_ouser;
                        r_ovalid <= 1'b1;
                        if (r_kind != K_NONE) begin
                            r_bacc <= '0;
                            r_tacc <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

/* sv/blflg_div.sv */
// Restoring divider, one quotient bit per cycle
module blflg_div
    import blflg_pkg::*;
#(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_shift = {r_rem, r_q[DIVIDEND_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_fits  = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIVIDEND_W);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (w_fits) begin
                r_rem <= w_diff[DIVISOR_W-1:0];
                r_q   <= {r_q[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIVISOR_W-1:0];
                r_q   <= {r_q[DIVIDEND_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

/* sv/blflg_checker.sv */
// Port-level checks for the governor
module blflg_checker
    import blflg_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // one sample at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while previous one still in work");

    // a pending output word stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output word dropped or changed while stalled");

    // go_max only comes with a decision
    a_gomax_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[OUT_GOMAX_BIT] |-> m_axis_tuser[OUT_DECIDED_BIT])
        else $error("go_max without decided");

    // level field is zero unless a level is chosen
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[OUT_GOMAX_BIT] || !m_axis_tuser[OUT_DECIDED_BIT])
        |-> m_axis_tdata[OUT_LEVEL_LSB +: LEVEL_W] == '0)
        else $error("new_level set without a level decision");

endmodule

bind busy_load_frequency_level_governor blflg_checker u_blflg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
